// File: sv/aie_pkg.sv
// Shared types, opcode constants and the bitmask-immediate decode for the
// AArch64 immediate ALU execute block. No dependencies.
`default_nettype none

package aie_pkg;

    localparam int unsigned REG_COUNT = 32;
    localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);
    localparam int unsigned XLEN      = 64;
    localparam int unsigned INSN_W    = 32;
    localparam int unsigned FLAGS_W   = 4;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes.
    localparam int unsigned S_DATA_W = 104;
    localparam int unsigned M_DATA_W = 80;
    localparam int unsigned M_USER_W = 2;

    // Item kinds on the input tuser bit.
    localparam logic FUNC_EXEC = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // op0 field, instruction bits 25:23.
    localparam logic [2:0] OP0_ADD_SUB = 3'b010;
    localparam logic [2:0] OP0_LOGICAL = 3'b100;

    // opc field of the logical immediate group.
    localparam logic [1:0] OPC_AND  = 2'b00;
    localparam logic [1:0] OPC_ORR  = 2'b01;
    localparam logic [1:0] OPC_EOR  = 2'b10;
    localparam logic [1:0] OPC_ANDS = 2'b11;

    localparam int unsigned IMM_SHIFT = 12;

    typedef struct packed {
        logic             reserved;
        logic [XLEN-1:0]  mask;
    } t_bmask;

    // Architectural bitmask decode. Each result bit is set when its position
    // inside the element, rotated by immr, falls within the run of ones.
    function automatic t_bmask bitmask_decode(logic       n,
                                              logic [5:0] imms,
                                              logic [5:0] immr,
                                              logic       is64);
        t_bmask     res;
        logic [6:0] comb;
        logic [5:0] levels;
        logic [5:0] s;
        logic [5:0] r;
        logic [5:0] pos;
        comb = {n, ~imms};
        if (comb[6]) begin
            levels = 6'h3F;
        end else if (comb[5]) begin
            levels = 6'h1F;
        end else if (comb[4]) begin
            levels = 6'h0F;
        end else if (comb[3]) begin
            levels = 6'h07;
        end else if (comb[2]) begin
            levels = 6'h03;
        end else if (comb[1]) begin
            levels = 6'h01;
        end else begin
            levels = 6'h00;
        end
        res.reserved = (levels == 6'h00) || ((imms & levels) == levels);
        s = imms & levels;
        r = immr & levels;
        for (int j = 0; j < XLEN; j++) begin
            pos = ((6'(j) & levels) + r) & levels;
            res.mask[j] = (pos <= s);
        end
        if (!is64) begin
            res.mask[XLEN-1:32] = '0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/arm64_imm_alu_execute.sv
// AArch64 data-processing-immediate execute stage with a 32 x 64-bit
// register file and NZCV flags. Depends on aie_pkg.
//
// Usage: each input item either loads a register (tuser = 1) or executes
// one instruction word (tuser = 0). ADD/ADDS/SUB/SUBS immediate (op0 = 2)
// and AND/ORR/EOR/ANDS immediate (op0 = 4) write Rd; other op0 values
// write nothing. Every item produces exactly one result item carrying the
// write (if any), the flags after the item and an undefined-encoding flag.
// The path is one input register, then decode, register read, adder or
// mask and register-file write done combinationally into the result
// register. One item per cycle is sustained while the receiver keeps
// tready high; an item sees the writes and flags of the item just before
// it because the register file is written as that item enters the result
// register. When the receiver stalls, the result register holds and the
// input register still fills, so tready on the input drops only when both
// stages are full. Reset clears both pipeline valids, the flags and the
// per-entry valid bits, so every register reads as zero until written.
`default_nettype none

module arm64_imm_alu_execute (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: instruction[31:0], load_index[36:32], load_value[100:37], zero pad
    input  wire logic [aie_pkg::S_DATA_W-1:0]    i_s_axis_tdata,
    // tuser: func[0]
    input  wire logic                            i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // tdata: dest_index[4:0], dest_value[68:5], nzcv[72:69], zero pad
    output logic [aie_pkg::M_DATA_W-1:0]         o_m_axis_tdata,
    // tuser: wrote[0], undefined[1]
    output logic [aie_pkg::M_USER_W-1:0]         o_m_axis_tuser
);

    localparam int unsigned IW = aie_pkg::REG_IDX_W;
    localparam int unsigned XW = aie_pkg::XLEN;
    localparam int unsigned FW = aie_pkg::FLAGS_W;

    // Input register.
    logic                         r_s1_vld;
    logic                         r_s1_func;
    logic [aie_pkg::INSN_W-1:0]   r_s1_insn;
    logic [IW-1:0]                r_s1_lidx;
    logic [XW-1:0]                r_s1_lval;

    // Result register.
    logic                         r_out_vld;
    logic                         r_out_wrote;
    logic                         r_out_undef;
    logic [IW-1:0]                r_out_dst;
    logic [XW-1:0]                r_out_val;
    logic [FW-1:0]                r_out_nzcv;

    // Architectural state.
    logic [XW-1:0]                r_regs [aie_pkg::REG_COUNT];
    logic [aie_pkg::REG_COUNT-1:0] r_reg_vld;
    logic [FW-1:0]                r_flags;

    logic                         s1_adv;
    logic                         s_accept;

    logic                         n_wrote;
    logic                         n_undef;
    logic [IW-1:0]                n_dst;
    logic [XW-1:0]                n_val;
    logic [FW-1:0]                n_flags;

    logic [2:0]                   op0;
    logic [1:0]                   opc;
    logic                         is64;
    logic [IW-1:0]                rd;
    logic [IW-1:0]                rn;
    logic [XW-1:0]                opa;
    logic [XW-1:0]                dmask;
    logic [XW-1:0]                imm;
    logic [XW-1:0]                x;
    logic [XW-1:0]                y;
    logic [XW:0]                  sum;
    logic [XW-1:0]                res;
    logic                         carry;
    logic                         sx;
    logic                         sy;
    logic                         sr;
    logic                         nf;
    logic                         zf;
    logic                         vf;
    aie_pkg::t_bmask              bm;

    assign s1_adv          = r_s1_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_vld || s1_adv;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Instruction fields and the shared datapath.
    always_comb begin
        op0   = r_s1_insn[25:23];
        opc   = r_s1_insn[30:29];
        is64  = r_s1_insn[31];
        rd    = r_s1_insn[IW-1:0];
        rn    = r_s1_insn[5 +: IW];
        opa   = r_reg_vld[rn] ? r_regs[rn] : '0;
        dmask = is64 ? {XW{1'b1}} : {{(XW-32){1'b0}}, {32{1'b1}}};

        imm = {{(XW-12){1'b0}}, r_s1_insn[21:10]};
        if (r_s1_insn[22]) begin
            imm = imm << aie_pkg::IMM_SHIFT;
        end

        // Operands are masked to 32 bits in 32-bit mode, so bit 32 of the
        // sum is the 32-bit carry out.
        x     = opa & dmask;
        y     = (r_s1_insn[30] ? ~imm : imm) & dmask;
        sum   = {1'b0, x} + {1'b0, y} + {{XW{1'b0}}, r_s1_insn[30]};
        res   = sum[XW-1:0] & dmask;
        carry = is64 ? sum[XW] : sum[32];
        sx    = is64 ? x[XW-1] : x[31];
        sy    = is64 ? y[XW-1] : y[31];
        sr    = is64 ? res[XW-1] : res[31];
        vf    = (sx == sy) && (sr != sx);

        bm = aie_pkg::bitmask_decode(r_s1_insn[22], r_s1_insn[15:10],
                                     r_s1_insn[21:16], is64);
    end

    always_comb begin
        n_wrote = 1'b0;
        n_undef = 1'b0;
        n_dst   = '0;
        n_val   = '0;
        n_flags = r_flags;
        nf      = 1'b0;
        zf      = 1'b0;
        if (r_s1_func == aie_pkg::FUNC_LOAD) begin
            n_wrote = 1'b1;
            n_dst   = r_s1_lidx;
            n_val   = r_s1_lval;
        end else begin
            case (op0)
                aie_pkg::OP0_ADD_SUB: begin
                    nf      = sr;
                    zf      = (res == '0);
                    n_wrote = 1'b1;
                    n_dst   = rd;
                    n_val   = res;
                    if (r_s1_insn[29]) begin
                        n_flags = {nf, zf, carry, vf};
                    end
                end
                aie_pkg::OP0_LOGICAL: begin
                    if ((!is64 && r_s1_insn[22]) || bm.reserved) begin
                        n_undef = 1'b1;
                    end else begin
                        case (opc)
                            aie_pkg::OPC_ORR: n_val = opa | bm.mask;
                            aie_pkg::OPC_EOR: n_val = opa ^ bm.mask;
                            default:          n_val = opa & bm.mask;
                        endcase
                        n_val   = n_val & dmask;
                        nf      = is64 ? n_val[XW-1] : n_val[31];
                        zf      = (n_val == '0);
                        n_wrote = 1'b1;
                        n_dst   = rd;
                        if (opc == aie_pkg::OPC_ANDS) begin
                            n_flags = {nf, zf, 2'b00};
                        end
                    end
                end
                default: begin
                    n_wrote = 1'b0;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_flags   <= '0;
            r_reg_vld <= '0;
        end else begin
            if (s_accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_flags   <= n_flags;
                if (n_wrote) begin
                    r_reg_vld[n_dst] <= 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_func <= i_s_axis_tuser;
            r_s1_insn <= i_s_axis_tdata[31:0];
            r_s1_lidx <= i_s_axis_tdata[36:32];
            r_s1_lval <= i_s_axis_tdata[100:37];
        end
        if (s1_adv) begin
            r_out_wrote <= n_wrote;
            r_out_undef <= n_undef;
            r_out_dst   <= n_dst;
            r_out_val   <= n_val;
            r_out_nzcv  <= n_flags;
            if (n_wrote) begin
                r_regs[n_dst] <= n_val;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {7'b0, r_out_nzcv, r_out_val, r_out_dst};
    assign o_m_axis_tuser  = {r_out_undef, r_out_wrote};

endmodule

`default_nettype wire

// File: sv/aie_port_chk.sv
// Port-level assertions for arm64_imm_alu_execute and the bind that
// attaches them. Depends on aie_pkg.
`default_nettype none

module aie_port_chk (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    input  wire logic                         o_s_axis_tready,
    input  wire logic [aie_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic                         i_s_axis_tuser,
    input  wire logic                         o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    input  wire logic [aie_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    input  wire logic [aie_pkg::M_USER_W-1:0] o_m_axis_tuser
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // No result is shown in the cycle after a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A result without a write carries zero index and value.
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[68:0] == '0)
        else $error("non-write result carries a destination");

    // An undefined encoding never writes.
    a_undef_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> !o_m_axis_tuser[0])
        else $error("undefined encoding reported a write");

endmodule

bind arm64_imm_alu_execute aie_port_chk u_aie_port_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
